// ===== rtl/stimulator_session_controller_unit_defines.svh =====
// Assertion helpers shared by the session controller RTL.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef STIMULATOR_SESSION_CONTROLLER_UNIT_DEFINES_SVH
`define STIMULATOR_SESSION_CONTROLLER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssc_pkg.sv =====
`timescale 1ns / 1ps

package ssc_pkg;

    // Event codes carried in the action field
    typedef enum logic [3:0] {
        ACT_TICK      = 4'd0,
        ACT_POWER     = 4'd1,
        ACT_CONTACT   = 4'd2,
        ACT_CYCLE     = 4'd3,
        ACT_FREQUENCY = 4'd4,
        ACT_WAVEFORM  = 4'd5,
        ACT_SAVE      = 4'd6,
        ACT_UP        = 4'd7,
        ACT_DOWN      = 4'd8,
        ACT_FAULT     = 4'd9
    } ssc_action_t;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_ON       = 2'd1,
        MODE_DISABLED = 2'd2
    } ssc_mode_t;

    typedef enum logic [1:0] {
        WARN_NONE     = 2'd0,
        WARN_LOW      = 2'd1,
        WARN_CRITICAL = 2'd2
    } ssc_warn_t;

    typedef enum logic [1:0] {
        CFG_IDLE_LIMIT       = 2'd0,
        CFG_FAULT_LIMIT      = 2'd1,
        CFG_LOW_BATTERY      = 2'd2,
        CFG_CRITICAL_BATTERY = 2'd3
    } ssc_cfg_index_t;

    localparam int CFG_DATA_W = 16;

    localparam logic [11:0] CYCLE_LEN_SHORT  = 12'd1200;
    localparam logic [11:0] CYCLE_LEN_MEDIUM = 12'd2400;
    localparam logic [11:0] CYCLE_LEN_LONG   = 12'd3600;

    localparam logic [9:0]  CURRENT_RESET = 10'd100;
    localparam logic [10:0] CURRENT_UP    = 11'd100;
    localparam logic [10:0] CURRENT_MAX   = 11'd500;
    localparam logic [9:0]  CURRENT_DOWN  = 10'd50;
    localparam logic [9:0]  CURRENT_FAULT = 10'd701;

    localparam logic [15:0] IDLE_LIMIT_RESET       = 16'd1800;
    localparam logic [9:0]  FAULT_LIMIT_RESET      = 10'd700;
    localparam logic [6:0]  LOW_BATTERY_RESET      = 7'd5;
    localparam logic [6:0]  CRITICAL_BATTERY_RESET = 7'd2;

    typedef struct packed {
        logic [3:0] action;
        logic       skin_touch;
        logic [6:0] battery_level;
    } ssc_event_t;

    typedef struct packed {
        logic [15:0] idle_limit_seconds;
        logic [9:0]  fault_current_limit;
        logic [6:0]  low_battery_level;
        logic [6:0]  critical_battery_level;
    } ssc_cfg_t;

    typedef struct packed {
        logic        device_on;
        logic        fault_disabled;
        logic        therapy_on;
        logic        save_on;
        logic [1:0]  cycle_mode;
        logic [11:0] countdown_seconds;
        logic [11:0] time_left;
        logic [1:0]  frequency_mode;
        logic [1:0]  waveform_mode;
        logic [9:0]  current_ua;
        logic [15:0] idle_seconds;
    } ssc_state_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  device_mode;
        logic        therapy_running;
        logic [11:0] seconds_left;
        logic [9:0]  drive_current_ua;
        logic [1:0]  cycle_setting;
        logic [1:0]  frequency_setting;
        logic [1:0]  waveform_setting;
        logic        saving_enabled;
        logic [1:0]  battery_warning;
        logic        record_saved;
        logic [11:0] saved_duration;
    } ssc_result_t;

    // Advance a three-way setting, wrapping to the first value
    function automatic logic [1:0] next3(input logic [1:0] v);
        next3 = (v >= 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    // Countdown length for a cycle setting
    function automatic logic [11:0] cycle_len(input logic [1:0] mode);
        case (mode)
            2'd1:    cycle_len = CYCLE_LEN_MEDIUM;
            2'd2:    cycle_len = CYCLE_LEN_LONG;
            default: cycle_len = CYCLE_LEN_SHORT;
        endcase
    endfunction

endpackage

// ===== rtl/ssc_if.sv =====
`timescale 1ns / 1ps

// Event channel
interface ssc_event_if;
    logic       valid;
    logic       ready;
    logic [3:0] action;
    logic       skin_touch;
    logic [6:0] battery_level;

    modport source (output valid, action, skin_touch, battery_level, input ready);
    modport sink   (input valid, action, skin_touch, battery_level, output ready);
endinterface

// Result channel
interface ssc_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [1:0]  device_mode;
    logic        therapy_running;
    logic [11:0] seconds_left;
    logic [9:0]  drive_current_ua;
    logic [1:0]  cycle_setting;
    logic [1:0]  frequency_setting;
    logic [1:0]  waveform_setting;
    logic        saving_enabled;
    logic [1:0]  battery_warning;
    logic        record_saved;
    logic [11:0] saved_duration;

    modport source (
        output valid, status, device_mode, therapy_running, seconds_left,
               drive_current_ua, cycle_setting, frequency_setting, waveform_setting,
               saving_enabled, battery_warning, record_saved, saved_duration,
        input  ready
    );
    modport sink (
        input  valid, status, device_mode, therapy_running, seconds_left,
               drive_current_ua, cycle_setting, frequency_setting, waveform_setting,
               saving_enabled, battery_warning, record_saved, saved_duration,
        output ready
    );
endinterface

// ===== rtl/ssc_in_reg.sv =====
`timescale 1ns / 1ps

module ssc_in_reg
    import ssc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ssc_event_if.sink   command,
    input  logic        advance,
    output logic        pending,
    output ssc_event_t  evt
);

    logic       valid_reg;
    logic       valid_next;
    ssc_event_t evt_reg;

    // Take a new transaction when empty or whenever the held one moves on this cycle
    assign command.ready = !valid_reg || advance;
    assign valid_next    = command.valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next && command.ready || (valid_reg && !advance);
        end
    end

    // Capture payload on acceptance
    always_ff @(posedge clk)
    begin
        if (command.valid && command.ready)
        begin
            evt_reg.action        <= command.action;
            evt_reg.skin_touch    <= command.skin_touch;
            evt_reg.battery_level <= command.battery_level;
        end
    end

    assign pending = valid_reg;
    assign evt     = evt_reg;

endmodule

// ===== rtl/ssc_step.sv =====
`timescale 1ns / 1ps

module ssc_step
    import ssc_pkg::*;
(
    input  ssc_state_t  st,
    input  ssc_cfg_t    cfg,
    input  ssc_event_t  evt,
    output ssc_state_t  st_next,
    output ssc_result_t res
);

    typedef struct packed {
        ssc_state_t  st;
        logic        rec_valid;
        logic [11:0] rec_duration;
    } ssc_work_t;

    // End a running session, saving a record when asked and enabled
    function automatic ssc_work_t finish_session(input ssc_work_t w, input logic want_save);
        ssc_work_t r;
        r = w;
        if (r.st.therapy_on)
        begin
            r.st.therapy_on = 1'b0;
            if (want_save && r.st.save_on)
            begin
                r.rec_valid    = 1'b1;
                r.rec_duration = (r.st.time_left > r.st.countdown_seconds) ? 12'd0 :
                                 r.st.countdown_seconds - r.st.time_left;
                r.st.time_left = r.st.countdown_seconds;
            end
        end
        return r;
    endfunction

    // Power button: refused while disabled and off
    function automatic ssc_work_t press_power(input ssc_work_t w);
        ssc_work_t r;
        r = w;
        if (!(r.st.fault_disabled && !r.st.device_on))
        begin
            r.st.idle_seconds = '0;
            r = finish_session(r, 1'b1);
            r.st.device_on = !r.st.device_on;
        end
        return r;
    endfunction

    always_comb
    begin
        ssc_work_t   w;
        logic        status;
        ssc_warn_t   warn;
        logic [10:0] up_sum;

        w.st           = st;
        w.rec_valid    = 1'b0;
        w.rec_duration = '0;
        status         = 1'b0;
        warn           = WARN_NONE;
        up_sum         = {1'b0, st.current_ua} + CURRENT_UP;

        case (evt.action)
            ACT_TICK:
            begin
                if (w.st.device_on && !w.st.fault_disabled)
                begin
                    // Battery check first
                    if (evt.battery_level <= cfg.critical_battery_level)
                    begin
                        warn = WARN_CRITICAL;
                        w    = press_power(w);
                    end
                    else if (evt.battery_level <= cfg.low_battery_level)
                    begin
                        warn = WARN_LOW;
                    end
                    // Countdown
                    if (w.st.device_on && !w.st.fault_disabled && w.st.therapy_on)
                    begin
                        if (w.st.time_left != 12'd0)
                            w.st.time_left = w.st.time_left - 12'd1;
                        else
                            w = finish_session(w, 1'b1);
                    end
                    // Over-current disables and powers off
                    if (w.st.device_on && !w.st.fault_disabled &&
                        w.st.current_ua > cfg.fault_current_limit)
                    begin
                        w.st.fault_disabled = 1'b1;
                        w = press_power(w);
                    end
                    // Inactivity
                    if (w.st.therapy_on)
                    begin
                        w.st.idle_seconds = '0;
                    end
                    else
                    begin
                        w.st.idle_seconds = w.st.idle_seconds + 16'd1;
                        if (w.st.idle_seconds >= cfg.idle_limit_seconds)
                        begin
                            w.st.idle_seconds = '0;
                            w = press_power(w);
                        end
                    end
                end
            end
            ACT_POWER:
            begin
                if (w.st.fault_disabled && !w.st.device_on)
                    status = 1'b1;
                else
                    w = press_power(w);
            end
            ACT_CONTACT:
            begin
                if (evt.skin_touch)
                begin
                    if (!w.st.device_on || w.st.fault_disabled)
                        status = 1'b1;
                    else
                        w.st.therapy_on = 1'b1;
                end
                else
                begin
                    w = finish_session(w, 1'b0);
                end
            end
            ACT_CYCLE, ACT_FREQUENCY, ACT_WAVEFORM, ACT_SAVE, ACT_UP, ACT_DOWN:
            begin
                if (w.st.therapy_on || !w.st.device_on || w.st.fault_disabled)
                begin
                    status = 1'b1;
                end
                else
                begin
                    case (evt.action)
                        ACT_CYCLE:
                        begin
                            w.st.cycle_mode        = next3(w.st.cycle_mode);
                            w.st.countdown_seconds = cycle_len(w.st.cycle_mode);
                            w.st.time_left         = w.st.countdown_seconds;
                        end
                        ACT_FREQUENCY: w.st.frequency_mode = next3(w.st.frequency_mode);
                        ACT_WAVEFORM:  w.st.waveform_mode  = next3(w.st.waveform_mode);
                        ACT_SAVE:      w.st.save_on        = !w.st.save_on;
                        ACT_UP:
                        begin
                            w.st.current_ua = (up_sum > CURRENT_MAX) ? CURRENT_MAX[9:0] :
                                              up_sum[9:0];
                        end
                        default:
                        begin
                            w.st.current_ua = (w.st.current_ua < CURRENT_DOWN) ? 10'd0 :
                                              w.st.current_ua - CURRENT_DOWN;
                        end
                    endcase
                end
            end
            ACT_FAULT:
            begin
                if (!w.st.device_on || w.st.fault_disabled)
                    status = 1'b1;
                else
                    w.st.current_ua = CURRENT_FAULT;
            end
            default:
            begin
                status = 1'b0;
            end
        endcase

        st_next = w.st;

        // Assemble the visible state
        res.status            = status;
        res.device_mode       = w.st.fault_disabled ? MODE_DISABLED :
                                (w.st.device_on ? MODE_ON : MODE_OFF);
        res.therapy_running   = w.st.therapy_on;
        res.seconds_left      = w.st.time_left;
        res.drive_current_ua  = w.st.current_ua;
        res.cycle_setting     = w.st.cycle_mode;
        res.frequency_setting = w.st.frequency_mode;
        res.waveform_setting  = w.st.waveform_mode;
        res.saving_enabled    = w.st.save_on;
        res.battery_warning   = warn;
        res.record_saved      = w.rec_valid;
        res.saved_duration    = w.rec_duration;
    end

endmodule

// ===== rtl/ssc_out_reg.sv =====
`timescale 1ns / 1ps

module ssc_out_reg
    import ssc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ssc_result_if.source result,
    input  logic         load,
    input  ssc_result_t  res_d,
    output logic         space
);

    logic        valid_reg;
    logic        valid_next;
    ssc_result_t res_reg;

    // Free when empty or when the held transaction leaves this cycle
    assign space      = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_d;
    end

    assign result.valid             = valid_reg;
    assign result.status            = res_reg.status;
    assign result.device_mode       = res_reg.device_mode;
    assign result.therapy_running   = res_reg.therapy_running;
    assign result.seconds_left      = res_reg.seconds_left;
    assign result.drive_current_ua  = res_reg.drive_current_ua;
    assign result.cycle_setting     = res_reg.cycle_setting;
    assign result.frequency_setting = res_reg.frequency_setting;
    assign result.waveform_setting  = res_reg.waveform_setting;
    assign result.saving_enabled    = res_reg.saving_enabled;
    assign result.battery_warning   = res_reg.battery_warning;
    assign result.record_saved      = res_reg.record_saved;
    assign result.saved_duration    = res_reg.saved_duration;

endmodule

// ===== rtl/stimulator_session_controller_unit.sv =====
`timescale 1ns / 1ps
// Session controller for an electrotherapy stimulator. Each event transaction on
// command produces exactly one result transaction on result, in order. The block
// sustains one event per clock while result is not stalled: an event is captured
// in an input register, its whole state update is worked out in one pass of shallow
// logic and written to the session state and the result register at the same edge,
// so each result is presented from the result register, loaded as the event leaves
// the input register. Input and result registers each hold one transaction, so up
// to two events can be in flight while result is back-pressured. Configuration
// writes (cfg_wr_en, cfg_index, cfg_data) take effect at the next edge and must be
// made while no event is in flight; there is no clearing pass after reset.
`include "stimulator_session_controller_unit_defines.svh"

module stimulator_session_controller_unit
    import ssc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ssc_event_if.sink             command,
    ssc_result_if.source          result,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic        pending;
    logic        space;
    logic        advance;
    ssc_event_t  evt;
    ssc_state_t  st_reg;
    ssc_state_t  st_next;
    ssc_cfg_t    cfg_reg;
    ssc_result_t res_d;

    assign advance = pending && space;

    ssc_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command),
        .advance (advance),
        .pending (pending),
        .evt     (evt)
    );

    ssc_step u_step (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .evt     (evt),
        .st_next (st_next),
        .res     (res_d)
    );

    ssc_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .result (result),
        .load   (advance),
        .res_d  (res_d),
        .space  (space)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_limit_seconds     <= IDLE_LIMIT_RESET;
            cfg_reg.fault_current_limit    <= FAULT_LIMIT_RESET;
            cfg_reg.low_battery_level      <= LOW_BATTERY_RESET;
            cfg_reg.critical_battery_level <= CRITICAL_BATTERY_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IDLE_LIMIT:       cfg_reg.idle_limit_seconds     <= cfg_data[15:0];
                CFG_FAULT_LIMIT:      cfg_reg.fault_current_limit    <= cfg_data[9:0];
                CFG_LOW_BATTERY:      cfg_reg.low_battery_level      <= cfg_data[6:0];
                CFG_CRITICAL_BATTERY: cfg_reg.critical_battery_level <= cfg_data[6:0];
                default:              cfg_reg                        <= cfg_reg;
            endcase
        end
    end

    // Session state: advance once per event that moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.device_on         <= 1'b0;
            st_reg.fault_disabled    <= 1'b0;
            st_reg.therapy_on        <= 1'b0;
            st_reg.save_on           <= 1'b1;
            st_reg.cycle_mode        <= 2'd0;
            st_reg.countdown_seconds <= CYCLE_LEN_SHORT;
            st_reg.time_left         <= CYCLE_LEN_SHORT;
            st_reg.frequency_mode    <= 2'd0;
            st_reg.waveform_mode     <= 2'd0;
            st_reg.current_ua        <= CURRENT_RESET;
            st_reg.idle_seconds      <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    `SSC_ASSERT_SAME(a_fault_means_off, st_reg.fault_disabled, !st_reg.device_on,
        "device disabled by fault while still on")
    `SSC_ASSERT_SAME(a_current_bound, 1'b1, st_reg.current_ua <= CURRENT_FAULT,
        "drive current beyond the fault setting")
    `SSC_ASSERT_SAME(a_record_ends_session, result.valid && result.record_saved,
        !result.therapy_running, "session record emitted while therapy still runs")
    `SSC_ASSERT_NEXT(a_advance_fills_output, advance, result.valid,
        "event moved on but no result presented")

endmodule

// ===== tb/ssc_session_checker.sv =====
`timescale 1ns / 1ps

module ssc_session_checker
    import ssc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ssc_event_if                  command,
    ssc_result_if                 result,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           outstanding,
    output int unsigned           mismatch_count
);

    localparam int unsigned REPORT_LIMIT = 10;

    // Shadow of the controller: session state, limits and the reports still owed
    ssc_state_t  sess;
    ssc_cfg_t    limits;
    ssc_result_t awaited_reports[$];

    // Session record raised while working out the current event
    logic        record_now;
    logic [11:0] record_len;

    function automatic logic [1:0] rotate_setting(input logic [1:0] m);
        return (m >= 2'd2) ? 2'd0 : m + 2'd1;
    endfunction

    function automatic logic [11:0] session_length(input logic [1:0] m);
        case (m)
            2'd1:    return CYCLE_LEN_MEDIUM;
            2'd2:    return CYCLE_LEN_LONG;
            default: return CYCLE_LEN_SHORT;
        endcase
    endfunction

    function automatic string show_report(input ssc_result_t r);
        return $sformatf({"status=%0d mode=%0d run=%0d left=%0d cur=%0d cyc=%0d ",
                          "freq=%0d wave=%0d save=%0d warn=%0d rec=%0d dur=%0d"},
                         r.status, r.device_mode, r.therapy_running, r.seconds_left,
                         r.drive_current_ua, r.cycle_setting, r.frequency_setting,
                         r.waveform_setting, r.saving_enabled, r.battery_warning,
                         r.record_saved, r.saved_duration);
    endfunction

    // End a running session, recording its length when asked and saving is on
    task automatic close_session(input logic keep_record);
        if (sess.therapy_on) begin
            sess.therapy_on = 1'b0;
            if (keep_record && sess.save_on) begin
                record_now = 1'b1;
                record_len = (sess.time_left > sess.countdown_seconds) ? 12'd0 :
                             sess.countdown_seconds - sess.time_left;
                sess.time_left = sess.countdown_seconds;
            end
        end
    endtask

    // Power button: refused once the device is disabled and off
    task automatic toggle_power(output logic taken);
        if (sess.fault_disabled && !sess.device_on) begin
            taken = 1'b0;
        end
        else begin
            sess.idle_seconds = 16'd0;
            close_session(1'b1);
            sess.device_on = !sess.device_on;
            taken = 1'b1;
        end
    endtask

    // Apply one event to the shadow state and build the report it must produce
    task automatic advance_session(input ssc_event_t ev, output ssc_result_t rep);
        logic taken;
        logic refused;
        logic [1:0] warn;
        int unsigned cur;
        refused    = 1'b0;
        warn       = WARN_NONE;
        record_now = 1'b0;
        record_len = 12'd0;
        case (ev.action)
            ACT_TICK:
            begin
                if (sess.device_on && !sess.fault_disabled) begin
                    if (ev.battery_level <= limits.critical_battery_level) begin
                        warn = WARN_CRITICAL;
                        toggle_power(taken);
                    end
                    else if (ev.battery_level <= limits.low_battery_level) begin
                        warn = WARN_LOW;
                    end
                    if (sess.device_on && !sess.fault_disabled && sess.therapy_on) begin
                        if (sess.time_left > 12'd0)
                            sess.time_left = sess.time_left - 12'd1;
                        else
                            close_session(1'b1);
                    end
                    if (sess.device_on && !sess.fault_disabled &&
                        sess.current_ua > limits.fault_current_limit) begin
                        sess.fault_disabled = 1'b1;
                        toggle_power(taken);
                    end
                    if (sess.therapy_on) begin
                        sess.idle_seconds = 16'd0;
                    end
                    else begin
                        sess.idle_seconds = sess.idle_seconds + 16'd1;
                        if (sess.idle_seconds >= limits.idle_limit_seconds) begin
                            sess.idle_seconds = 16'd0;
                            toggle_power(taken);
                        end
                    end
                end
            end
            ACT_POWER:
            begin
                toggle_power(taken);
                refused = !taken;
            end
            ACT_CONTACT:
            begin
                if (ev.skin_touch) begin
                    if (!sess.device_on || sess.fault_disabled)
                        refused = 1'b1;
                    else
                        sess.therapy_on = 1'b1;
                end
                else begin
                    close_session(1'b0);
                end
            end
            ACT_CYCLE, ACT_FREQUENCY, ACT_WAVEFORM, ACT_SAVE, ACT_UP, ACT_DOWN:
            begin
                if (sess.therapy_on || !sess.device_on || sess.fault_disabled) begin
                    refused = 1'b1;
                end
                else begin
                    case (ev.action)
                        ACT_CYCLE:
                        begin
                            sess.cycle_mode        = rotate_setting(sess.cycle_mode);
                            sess.countdown_seconds = session_length(sess.cycle_mode);
                            sess.time_left         = sess.countdown_seconds;
                        end
                        ACT_FREQUENCY: sess.frequency_mode = rotate_setting(sess.frequency_mode);
                        ACT_WAVEFORM:  sess.waveform_mode = rotate_setting(sess.waveform_mode);
                        ACT_SAVE:      sess.save_on = !sess.save_on;
                        ACT_UP:
                        begin
                            cur = sess.current_ua + 100;
                            if (cur > 500)
                                cur = 500;
                            sess.current_ua = cur[9:0];
                        end
                        default:
                        begin
                            cur = sess.current_ua;
                            cur = (cur < 50) ? 0 : cur - 50;
                            sess.current_ua = cur[9:0];
                        end
                    endcase
                end
            end
            ACT_FAULT:
            begin
                if (!sess.device_on || sess.fault_disabled)
                    refused = 1'b1;
                else
                    sess.current_ua = CURRENT_FAULT;
            end
            default:
            begin
                // unused codes leave everything alone
            end
        endcase

        rep.status            = refused;
        rep.device_mode       = sess.fault_disabled ? MODE_DISABLED :
                                (sess.device_on ? MODE_ON : MODE_OFF);
        rep.therapy_running   = sess.therapy_on;
        rep.seconds_left      = sess.time_left;
        rep.drive_current_ua  = sess.current_ua;
        rep.cycle_setting     = sess.cycle_mode;
        rep.frequency_setting = sess.frequency_mode;
        rep.waveform_setting  = sess.waveform_mode;
        rep.saving_enabled    = sess.save_on;
        rep.battery_warning   = warn;
        rep.record_saved      = record_now;
        rep.saved_duration    = record_len;
    endtask

    task automatic log_failure(input string msg, input string detail);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
            if (detail != "")
                $display("    %s", detail);
        end
    endtask

    // Check and drop reports on result transactions, then pick up writes and new events
    always @(posedge clk or negedge rst_n) begin : watch
        ssc_event_t  ev;
        ssc_result_t got;
        ssc_result_t want;
        if (!rst_n) begin
            sess.device_on         = 1'b0;
            sess.fault_disabled    = 1'b0;
            sess.therapy_on        = 1'b0;
            sess.save_on           = 1'b1;
            sess.cycle_mode        = 2'd0;
            sess.countdown_seconds = CYCLE_LEN_SHORT;
            sess.time_left         = CYCLE_LEN_SHORT;
            sess.frequency_mode    = 2'd0;
            sess.waveform_mode     = 2'd0;
            sess.current_ua        = CURRENT_RESET;
            sess.idle_seconds      = 16'd0;
            limits.idle_limit_seconds     = IDLE_LIMIT_RESET;
            limits.fault_current_limit    = FAULT_LIMIT_RESET;
            limits.low_battery_level      = LOW_BATTERY_RESET;
            limits.critical_battery_level = CRITICAL_BATTERY_RESET;
            awaited_reports.delete();
            outstanding    = 0;
            mismatch_count = 0;
        end
        else begin
            if (result.valid && result.ready) begin
                got.status            = result.status;
                got.device_mode       = result.device_mode;
                got.therapy_running   = result.therapy_running;
                got.seconds_left      = result.seconds_left;
                got.drive_current_ua  = result.drive_current_ua;
                got.cycle_setting     = result.cycle_setting;
                got.frequency_setting = result.frequency_setting;
                got.waveform_setting  = result.waveform_setting;
                got.saving_enabled    = result.saving_enabled;
                got.battery_warning   = result.battery_warning;
                got.record_saved      = result.record_saved;
                got.saved_duration    = result.saved_duration;
                if (awaited_reports.size() == 0) begin
                    log_failure("result transaction with nothing awaited", show_report(got));
                end
                else begin
                    want = awaited_reports.pop_front();
                    if (got !== want)
                        log_failure({"result mismatch, expected ", show_report(want)},
                                    {"actual ", show_report(got)});
                end
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IDLE_LIMIT:  limits.idle_limit_seconds  = cfg_data[15:0];
                    CFG_FAULT_LIMIT: limits.fault_current_limit = cfg_data[9:0];
                    CFG_LOW_BATTERY: limits.low_battery_level   = cfg_data[6:0];
                    default:         limits.critical_battery_level = cfg_data[6:0];
                endcase
            end

            if (command.valid && command.ready) begin
                ev.action        = command.action;
                ev.skin_touch    = command.skin_touch;
                ev.battery_level = command.battery_level;
                advance_session(ev, want);
                awaited_reports.push_back(want);
            end

            outstanding = awaited_reports.size();
        end
    end

endmodule

// ===== tb/tb_stimulator_session_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_stimulator_session_controller_unit;
    import ssc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned COUNTDOWN_TICKS = 1203;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned outstanding;
    int unsigned mismatch_count;
    int unsigned events_sent;
    int unsigned quiet_cycles;
    int unsigned stall_left;
    bit          no_idling;
    bit          hold_off_req;

    ssc_event_if  command_ch ();
    ssc_result_if result_ch ();

    stimulator_session_controller_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ssc_session_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .command        (command_ch),
        .result         (result_ch),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    always #4 clk = ~clk;

    // Abort when neither channel moves a transaction for too long
    always @(posedge clk)
    begin
        if ((command_ch.valid && command_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stimulator_session_controller_unit test failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [6:0] random_level();
        logic [6:0] lvl;
        if ($urandom_range(0, 9) < 7)
            lvl = 7'($urandom_range(0, 100));
        else
            lvl = 7'($urandom_range(0, 12));
        return lvl;
    endfunction

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                if (hold_off_req)
                begin
                    stall_left   = HOLD_OFF_CYCLES;
                    hold_off_req = 1'b0;
                end
                else if (!no_idling && $urandom_range(0, 3) == 0)
                begin
                    stall_left = gap_length();
                end
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one event and hold it until the block takes it
    task automatic send_event(input logic [3:0] act, input logic touch, input logic [6:0] lvl);
        int unsigned gap;
        gap = no_idling ? 0 : gap_length();
        @(negedge clk);
        if (gap > 0)
        begin
            command_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command_ch.valid         <= 1'b1;
        command_ch.action        <= act;
        command_ch.skin_touch    <= touch;
        command_ch.battery_level <= lvl;
        @(posedge clk);
        while (command_ch.ready !== 1'b1) @(posedge clk);
        events_sent++;
    endtask

    task automatic send_random_fields(input logic [3:0] act);
        send_event(act, 1'($urandom_range(0, 1)), random_level());
    endtask

    // Stop offering and wait until every report has come back
    task automatic drain_results();
        @(negedge clk);
        command_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input ssc_cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(input logic [15:0] idle_lim, input logic [9:0] fault_lim,
                              input logic [6:0] low_lvl, input logic [6:0] crit_lvl);
        drain_results();
        write_reg(CFG_IDLE_LIMIT, CFG_DATA_W'(idle_lim));
        write_reg(CFG_FAULT_LIMIT, CFG_DATA_W'(fault_lim));
        write_reg(CFG_LOW_BATTERY, CFG_DATA_W'(low_lvl));
        write_reg(CFG_CRITICAL_BATTERY, CFG_DATA_W'(crit_lvl));
    endtask

    task automatic send_noise();
        int unsigned roll;
        logic [3:0] act;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            act = 4'($urandom_range(10, 15));
        else if (roll < 35)
            act = ACT_TICK;
        else
            act = 4'($urandom_range(int'(ACT_POWER), int'(ACT_FAULT)));
        send_random_fields(act);
    endtask

    // Typical use: maybe power, adjust settings, make contact, run, then maybe stop
    task automatic run_session();
        int unsigned ticks;
        if ($urandom_range(0, 2) == 0)
            send_random_fields(ACT_POWER);
        repeat ($urandom_range(0, 4))
            send_random_fields(4'($urandom_range(int'(ACT_CYCLE), int'(ACT_DOWN))));
        send_event(ACT_CONTACT, 1'b1, random_level());
        ticks = $urandom_range(1, 25);
        repeat (ticks)
        begin
            if ($urandom_range(0, 9) == 0)
                send_random_fields(4'($urandom_range(int'(ACT_CYCLE), int'(ACT_FAULT))));
            else
                send_event(ACT_TICK, 1'($urandom_range(0, 1)), random_level());
        end
        case ($urandom_range(0, 3))
            0: send_event(ACT_CONTACT, 1'b0, random_level());
            1: send_random_fields(ACT_POWER);
            2:
            begin
                send_event(ACT_CONTACT, 1'b0, random_level());
                send_event(ACT_CONTACT, 1'b1, random_level());
            end
            default: ;
        endcase
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned target;
        int unsigned roll;
        target = events_sent + count;
        while (events_sent < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                run_session();
            else if (roll < 62)
                drain_results();
            else
                repeat ($urandom_range(1, 5)) send_noise();
        end
    endtask

    initial
    begin
        command_ch.valid         = 1'b0;
        command_ch.action        = ACT_TICK;
        command_ch.skin_touch    = 1'b0;
        command_ch.battery_level = 7'd0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_IDLE_LIMIT;
        cfg_data  = '0;
        no_idling = 1'b0;
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Guards while off, then every setting, saturation and session handling
        send_event(ACT_TICK, 1'b0, 7'd100);
        send_event(ACT_CONTACT, 1'b1, 7'd0);
        send_event(ACT_FAULT, 1'b1, 7'd127);
        send_event(ACT_POWER, 1'b0, 7'd0);
        repeat (4) send_event(ACT_UP, 1'b0, 7'd0);
        send_event(ACT_UP, 1'b1, 7'd64);
        send_event(ACT_FAULT, 1'b0, 7'd0);
        send_event(ACT_UP, 1'b0, 7'd0);
        send_event(ACT_DOWN, 1'b0, 7'd0);
        send_event(ACT_CYCLE, 1'b0, 7'd0);
        send_event(ACT_FREQUENCY, 1'b0, 7'd0);
        send_event(ACT_WAVEFORM, 1'b0, 7'd0);
        send_event(ACT_SAVE, 1'b0, 7'd0);
        send_event(ACT_SAVE, 1'b0, 7'd0);
        send_event(ACT_CONTACT, 1'b1, 7'd0);
        send_event(ACT_CYCLE, 1'b0, 7'd0);
        send_event(ACT_TICK, 1'b0, 7'd5);
        send_event(ACT_CONTACT, 1'b0, 7'd0);
        send_event(ACT_CONTACT, 1'b0, 7'd0);
        send_event(ACT_CONTACT, 1'b1, 7'd0);
        send_event(ACT_TICK, 1'b1, 7'd2);
        send_event(4'd15, 1'b1, 7'd127);
        send_event(ACT_POWER, 1'b0, 7'd0);

        // Run one short-cycle session through to the end of its countdown
        send_event(ACT_CYCLE, 1'b0, 7'd0);
        send_event(ACT_CYCLE, 1'b0, 7'd0);
        send_event(ACT_CONTACT, 1'b1, 7'd0);
        repeat (COUNTDOWN_TICKS)
            send_event(ACT_TICK, 1'($urandom_range(0, 1)), 7'($urandom_range(6, 100)));

        // Long result hold-off while events keep coming
        set_limits(16'd1800, 10'd1023, 7'd100, 7'd0);
        hold_off_req = 1'b1;
        run_random(15);

        // Every tick critical, inactivity powers straight back on
        set_limits(16'd1, 10'd701, 7'd0, 7'd100);
        run_random(10);

        set_limits(16'd65535, 10'd1023, 7'd30, 7'd10);
        run_random(10);

        // Inactivity limit reached on every counting tick
        set_limits(16'd0, 10'd1023, 7'd5, 7'd2);
        run_random(8);

        // Back-to-back stretch with no gaps on either side
        set_limits(16'd20, 10'd701, 7'd50, 7'd25);
        no_idling = 1'b1;
        run_random(20);
        no_idling = 1'b0;

        // Over-current faults now disable the device for good
        set_limits(16'd1800, 10'd700, 7'd5, 7'd2);
        run_random(12);
        set_limits(16'd1800, 10'd0, 7'd5, 7'd2);
        run_random(5);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("stimulator_session_controller_unit test passed");
        else
            $display("stimulator_session_controller_unit test failed");
        $finish;
    end

endmodule

// ===== stimulator_session_controller_unit.f =====
+incdir+rtl
rtl/ssc_pkg.sv
rtl/ssc_if.sv
rtl/ssc_in_reg.sv
rtl/ssc_step.sv
rtl/ssc_out_reg.sv
rtl/stimulator_session_controller_unit.sv
tb/ssc_session_checker.sv
tb/tb_stimulator_session_controller_unit.sv
